// File: hw/rtl/ira_pkg.sv
// ----------------------------------------------------------------------------
// ira_pkg
// shared constants and types for the id range allocator
// ----------------------------------------------------------------------------
`default_nettype none
package ira_pkg;
  localparam int FREE_SLOTS = 16;
  localparam int ID_BITS = 32;
  localparam int SLOT_W = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int USED_W = $clog2(FREE_SLOTS + 1);
  localparam int ENTRY_W = 2 * ID_BITS;

  typedef logic [1:0] action_t;
  localparam action_t ACT_ALLOC_ONE = 2'd0;
  localparam action_t ACT_ALLOC_RANGE = 2'd1;
  localparam action_t ACT_FREE_ONE = 2'd2;
  localparam action_t ACT_FREE_RANGE = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK = 2'd0;
  localparam status_t ST_LIST_FULL = 2'd1;
  localparam status_t ST_EXHAUSTED = 2'd2;

  typedef struct packed {
    action_t     action;
    logic [31:0] entity;
    logic [31:0] range_end;
    logic [31:0] count;
  } req_t;

  typedef struct packed {
    logic [31:0] first_id;
    logic [31:0] end_id;
    status_t     status;
  } rsp_t;
endpackage
`default_nettype wire

// File: hw/rtl/ira_if.sv
// ----------------------------------------------------------------------------
// ira_req_if / ira_rsp_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
`default_nettype none
interface ira_req_if import ira_pkg::*; ;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ira_rsp_if import ira_pkg::*; ;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/ira_ram.sv
// ----------------------------------------------------------------------------
// ira_ram
// generic single-write, single-read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module ira_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/id_range_allocator_unit.sv
// ----------------------------------------------------------------------------
// id_range_allocator_unit
// first-fit id allocator over a free-range list held in one ram
// ----------------------------------------------------------------------------
// each list entry scanned is read (S_RD), then evaluated (S_EVAL); a scan with
// no match ends in S_DONE; when a range empties, later entries shift forward
// (S_SRD, S_SWR); a free that hits the mark or an empty free range skips the list
// one item at a time: ready again in the cycle after the result leaves;
// the list scan and compaction through the single ram read port set the rate
// reset clears the high-water mark and fill count; ram contents stay
// undefined and only entries below the fill count are ever read
`default_nettype none
module id_range_allocator_unit import ira_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  ira_req_if.sink   req,
  ira_rsp_if.source rsp
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010, // read address presented
    S_EVAL  = 7'b0000100, // entry data valid
    S_SRD   = 7'b0001000, // shift: read next entry
    S_SWR   = 7'b0010000, // shift: write it one place forward
    S_DONE  = 7'b0100000, // decide at end of scan
    S_OUT   = 7'b1000000
  } state_t;

  localparam logic [ID_BITS-1:0] ID_MAX = '1;

  state_t              state;
  req_t                cur;
  logic [ID_BITS-1:0]  high_mark;
  logic [USED_W-1:0]   free_used;
  logic [USED_W-1:0]   idx;      // scan / shift position
  rsp_t                res;

  // ram port signals
  logic                we;
  logic [SLOT_W-1:0]   waddr, raddr;
  logic [ENTRY_W-1:0]  wdata, rdata;

  ira_ram #(.WIDTH(ENTRY_W), .DEPTH(FREE_SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic [ID_BITS-1:0] ent, rend, fb, fe, len, cnt;
  logic [ID_BITS-1:0] one;
  assign one  = ID_BITS'(1);
  assign ent  = ID_BITS'(cur.entity);
  assign rend = ID_BITS'(cur.range_end);
  assign cnt  = ID_BITS'(cur.count);
  assign fb   = rdata[ENTRY_W-1:ID_BITS];
  assign fe   = rdata[ID_BITS-1:0];
  assign len  = fe - fb;

  // count compared at 33 bits so ID_BITS below 32 stays exact
  logic cnt_fits;
  assign cnt_fits = {1'b0, len} >= {1'b0, cur.count} ;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.data  = res;

  logic last_entry;
  assign last_entry = (idx + USED_W'(1)) >= free_used;

  always_comb begin
    we = 1'b0;
    waddr = idx[SLOT_W-1:0];
    wdata = rdata;
    raddr = idx[SLOT_W-1:0];
    if (state == S_EVAL) begin
      case (cur.action)
        ACT_ALLOC_ONE, ACT_ALLOC_RANGE: begin
          we = (cur.action == ACT_ALLOC_ONE) || cnt_fits;
          wdata = {fb + ((cur.action == ACT_ALLOC_ONE) ? one : cnt), fe};
        end
        ACT_FREE_ONE: begin
          if (fe == ent) begin
            we = 1'b1; wdata = {fb, fe + one};
          end else if (fb - one == ent) begin
            we = 1'b1; wdata = {ent, fe};
          end
        end
        default: begin
          if (fe == ent) begin
            we = 1'b1; wdata = {fb, rend};
          end else if (fb == rend) begin
            we = 1'b1; wdata = {ent, fe};
          end
        end
      endcase
    end else if (state == S_SRD) begin
      raddr = SLOT_W'(idx + USED_W'(1));
    end else if (state == S_SWR) begin
      we = 1'b1;
    end else if (state == S_DONE) begin
      waddr = free_used[SLOT_W-1:0];
      wdata = {ent, (cur.action == ACT_FREE_ONE) ? ent + one : rend};
      we = (cur.action[1]) && (free_used < USED_W'(FREE_SLOTS)) &&
           !(cur.action == ACT_FREE_RANGE && rend == ent);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      high_mark <= '0;
      free_used <= '0;
      idx       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur <= req.data;
            res <= '0;
            idx <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          // frees that hit the mark, free ranges ending at it, or empty free ranges, skip the list
          if (cur.action == ACT_FREE_ONE && ent == high_mark) begin
            high_mark <= high_mark - one;
            state <= S_OUT;
          end else if (cur.action == ACT_FREE_RANGE && rend == ent) begin
            state <= S_OUT;
          end else if (cur.action == ACT_FREE_RANGE && rend - one == high_mark) begin
            high_mark <= ent - one;
            state <= S_OUT;
          end else if (idx >= free_used) begin
            state <= S_DONE;
          end else begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          state <= S_RD;
          idx <= idx + USED_W'(1);
          case (cur.action)
            ACT_ALLOC_ONE, ACT_ALLOC_RANGE: begin
              if (cur.action == ACT_ALLOC_ONE || cnt_fits) begin
                res.first_id <= 32'(fb);
                res.end_id <= 32'(wdata[ENTRY_W-1:ID_BITS]);
                idx <= idx;
                if (wdata[ENTRY_W-1:ID_BITS] == fe) begin
                  state <= last_entry ? S_OUT : S_SRD;
                  free_used <= free_used - USED_W'(1);
                end else begin
                  state <= S_OUT;
                end
              end
            end
            default: begin
              if (we) state <= S_OUT;
            end
          endcase
        end
        S_SRD: begin
          state <= S_SWR;
        end
        S_SWR: begin
          // free_used already lowered, so idx reaching it ends the shift
          state <= ((idx + USED_W'(1)) >= free_used) ? S_OUT : S_SRD;
          idx <= idx + USED_W'(1);
        end
        S_DONE: begin
          state <= S_OUT;
          case (cur.action)
            ACT_ALLOC_ONE: begin
              if (high_mark == ID_MAX) begin
                res.status <= ST_EXHAUSTED;
              end else begin
                high_mark <= high_mark + one;
                res.first_id <= 32'(high_mark + one);
                res.end_id <= 32'(high_mark + one + one);
              end
            end
            ACT_ALLOC_RANGE: begin
              if ({1'b0, cur.count} > {1'b0, ID_MAX - high_mark}) begin
                res.status <= ST_EXHAUSTED;
              end else begin
                high_mark <= high_mark + cnt;
                res.first_id <= 32'(high_mark + one);
                res.end_id <= 32'(high_mark + one + cnt);
              end
            end
            default: begin
              if (we) free_used <= free_used + USED_W'(1);
              else res.status <= ST_LIST_FULL;
            end
          endcase
        end
        S_OUT: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/ira_checker.sv
// ----------------------------------------------------------------------------
// ira_checker
// port-level checks for the id range allocator
// ----------------------------------------------------------------------------
`default_nettype none
module ira_checker import ira_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp_data
);
  // one item in flight: never ready while a result is shown
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid)) else $error("ready while result pending");
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.status != 2'd3) else $error("bad status");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != ST_OK |-> rsp_data.first_id == 0 &&
    rsp_data.end_id == 0) else $error("ids on error");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result dropped");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready) else $error("second accept");
endmodule

bind id_range_allocator_unit ira_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
`default_nettype wire

// File: test/tb_id_range_allocator_unit.sv
// ----------------------------------------------------------------------------
// tb_id_range_allocator_unit
// self-checking bench: directed and random allocate/free traffic with a
// first-fit free-list predictor, random idling on both channels and one
// long result stall that backs the block up into its request port
// ----------------------------------------------------------------------------
`default_nettype none
module tb_id_range_allocator_unit;
  import ira_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1320;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 4 * FREE_SLOTS + 20;
  localparam int HOLD_CYCLES  = 600;
  localparam int HOLD_AT_ITEM = 400;

  // free-list shadow: predicts each result and keeps the expected ones in order
  class id_pool_scoreboard;
    logic [31:0] mark;
    logic [31:0] fbeg [FREE_SLOTS];
    logic [31:0] fend [FREE_SLOTS];
    int          used;
    rsp_t        expected_q [$];
    int          errors;

    function new();
      mark = '0;
      used = 0;
      errors = 0;
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    function void drop_entry(int k);
      for (int i = k; i < used - 1; i++) begin
        fbeg[i] = fbeg[i + 1];
        fend[i] = fend[i + 1];
      end
      used--;
    endfunction

    // returns 1 when the list is full and the range is dropped
    function bit add_entry(logic [31:0] b, logic [31:0] e);
      if (used >= FREE_SLOTS) return 1'b1;
      fbeg[used] = b;
      fend[used] = e;
      used++;
      return 1'b0;
    endfunction

    function rsp_t allocate_or_release(req_t r);
      rsp_t        o;
      bit          done;
      logic [31:0] len;
      o = '0;
      o.status = ST_OK;
      done = 1'b0;
      case (r.action)
        ACT_ALLOC_ONE: begin
          if (used == 0) begin
            if (mark == '1) begin
              o.status = ST_EXHAUSTED;
            end else begin
              mark = mark + 1;
              o.first_id = mark;
              o.end_id = mark + 1;
            end
          end else begin
            o.first_id = fbeg[0];
            o.end_id = fbeg[0] + 1;
            fbeg[0] = o.end_id;
            if (fbeg[0] == fend[0]) drop_entry(0);
          end
        end
        ACT_ALLOC_RANGE: begin
          for (int i = 0; i < used && !done; i++) begin
            len = fend[i] - fbeg[i];
            if (len >= r.count) begin
              o.first_id = fbeg[i];
              o.end_id = fbeg[i] + r.count;
              fbeg[i] = o.end_id;
              if (fbeg[i] == fend[i]) drop_entry(i);
              done = 1'b1;
            end
          end
          if (!done) begin
            if (r.count > ~mark) begin
              o.status = ST_EXHAUSTED;
            end else begin
              o.first_id = mark + 1;
              o.end_id = mark + 1 + r.count;
              mark = mark + r.count;
            end
          end
        end
        ACT_FREE_ONE: begin
          if (r.entity == mark) begin
            mark = mark - 1;
          end else begin
            for (int i = 0; i < used && !done; i++) begin
              if (fend[i] == r.entity) begin
                fend[i] = fend[i] + 1;
                done = 1'b1;
              end else if (fbeg[i] - 1 == r.entity) begin
                fbeg[i] = r.entity;
                done = 1'b1;
              end
            end
            if (!done && add_entry(r.entity, r.entity + 1)) o.status = ST_LIST_FULL;
          end
        end
        default: begin
          if (r.range_end != r.entity) begin
            if (r.range_end - 1 == mark) begin
              mark = r.entity - 1;
            end else begin
              for (int i = 0; i < used && !done; i++) begin
                if (fend[i] == r.entity) begin
                  fend[i] = r.range_end;
                  done = 1'b1;
                end else if (fbeg[i] == r.range_end) begin
                  fbeg[i] = r.entity;
                  done = 1'b1;
                end
              end
              if (!done && add_entry(r.entity, r.range_end)) o.status = ST_LIST_FULL;
            end
          end
        end
      endcase
      return o;
    endfunction

    function void note_request(req_t r);
      expected_q.push_back(allocate_or_release(r));
    endfunction

    task check_result(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected: %h", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.first_id !== want.first_id)
        report($sformatf("first_id %h, want %h", got.first_id, want.first_id));
      if (got.end_id !== want.end_id)
        report($sformatf("end_id %h, want %h", got.end_id, want.end_id));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
    endtask
  endclass

  logic clk;
  logic rst;
  ira_req_if req_ch ();
  ira_rsp_if rsp_ch ();

  id_range_allocator_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  id_pool_scoreboard pool = new();
  bit hold_results;   // raised by the sender to ask for the long result stall
  int sent_items;
  int cycles;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // cycle counter doubles as the watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // both monitors read pre-edge values, so ordering within the step is irrelevant
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) pool.note_request(req_ch.data);
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) pool.check_result(rsp_ch.data);
  end

  // idle length: runs of no idling, otherwise mostly short with the odd long gap
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one request, held until the block takes it; valid stays high between items unless a gap is picked
  task automatic send_item(req_t r, bit calm);
    int gap;
    gap = pick_gap(calm);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_items++;
    if (sent_items == HOLD_AT_ITEM) hold_results = 1'b1;
  endtask

  function automatic req_t make_req(action_t a, logic [31:0] ent, logic [31:0] rend,
                                    logic [31:0] cnt);
    req_t r;
    r.action = a;
    r.entity = ent;
    r.range_end = rend;
    r.count = cnt;
    return r;
  endfunction

  // an id worth freeing: near the mark, next to a free range, or anywhere
  function automatic logic [31:0] pick_free_id();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 40) return pool.mark - $urandom_range(0, 20);
    if (r < 50) return pool.mark;
    if (r < 80 && pool.used > 0) begin
      k = $urandom_range(0, pool.used - 1);
      return ($urandom_range(0, 1) != 0) ? pool.fend[k] : pool.fbeg[k] - 1;
    end
    return $urandom();
  endfunction

  // random request: mostly plausible traffic against the current pool state
  function automatic req_t random_req();
    req_t        r;
    int          sel;
    logic [31:0] span;
    r = make_req(action_t'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom());
    sel = $urandom_range(0, 99);
    case (r.action)
      ACT_ALLOC_RANGE: begin
        if (sel < 70) r.count = $urandom_range(1, 8);
        else if (sel < 80) r.count = '0;
        else if (sel < 90) r.count = $urandom_range(1, 1000);
      end
      ACT_FREE_ONE: r.entity = pick_free_id();
      ACT_FREE_RANGE: begin
        span = $urandom_range(1, 16);
        if (sel < 12) begin
          // top of the mark: lowers it, sometimes all the way back
          r.range_end = pool.mark + 1;
          r.entity = ($urandom_range(0, 3) == 0) ? 32'd1 : pool.mark + 1 - span;
        end else if (sel < 20) begin
          r.range_end = r.entity;
        end else if (sel < 90) begin
          r.entity = pick_free_id();
          r.range_end = r.entity + span;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // result side: random stalls, calm stretches and the one long hold-off
  initial begin
    int stall_left;
    bit calm;
    stall_left = 0;
    calm = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_results) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
        rsp_ch.ready <= 1'b1;
      end else begin
        if ($urandom_range(0, 149) == 0) calm = !calm;
        if (stall_left > 0) begin
          stall_left--;
          rsp_ch.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 3) begin
          stall_left = $urandom_range(10, 40);
          rsp_ch.ready <= 1'b0;
        end else begin
          rsp_ch.ready <= calm || ($urandom_range(0, 99) < 70);
        end
      end
    end
  end

  // request side
  initial begin
    bit calm;
    cycles = 0;
    sent_items = 0;
    hold_results = 1'b0;
    calm = 1'b0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // basics: first id, range, empty range, growing a range at both ends
    send_item(make_req(ACT_ALLOC_ONE, '0, '0, '0), calm);
    send_item(make_req(ACT_ALLOC_RANGE, '0, '0, 32'd4), calm);
    send_item(make_req(ACT_ALLOC_RANGE, '0, '0, 32'd0), calm);
    send_item(make_req(ACT_FREE_ONE, 32'd3, '0, '0), calm);
    send_item(make_req(ACT_FREE_ONE, 32'd4, '0, '0), calm);
    send_item(make_req(ACT_FREE_RANGE, 32'd1, 32'd3, '0), calm);
    send_item(make_req(ACT_ALLOC_ONE, '0, '0, '0), calm);
    send_item(make_req(ACT_ALLOC_RANGE, '0, '0, 32'd2), calm);
    // empty free range is ignored, freeing the top id lowers the mark
    send_item(make_req(ACT_FREE_RANGE, 32'd9, 32'd9, '0), calm);
    send_item(make_req(ACT_FREE_ONE, pool.mark, '0, '0), calm);
    // draining the list, then running the mark to the top of the id space
    send_item(make_req(ACT_ALLOC_ONE, '1, '1, '1), calm);
    send_item(make_req(ACT_ALLOC_RANGE, '0, '0, ~pool.mark), calm);
    send_item(make_req(ACT_ALLOC_ONE, '0, '0, '0), calm);
    send_item(make_req(ACT_ALLOC_RANGE, '0, '0, 32'd1), calm);
    send_item(make_req(ACT_ALLOC_RANGE, '0, '0, '1), calm);
    send_item(make_req(ACT_FREE_ONE, '1, '0, '0), calm);
    // range ending at the mark brings it back down
    send_item(make_req(ACT_FREE_RANGE, 32'd6, 32'hFFFF_FFFF, '0), calm);
    // wrapping free range, then a bogus double free
    send_item(make_req(ACT_FREE_RANGE, 32'hFFFF_FFF0, 32'd0, '0), calm);
    send_item(make_req(ACT_FREE_RANGE, 32'hFFFF_FFF0, 32'd0, '0), calm);
    // non-adjacent frees until the list overflows
    for (int i = 0; i < FREE_SLOTS; i++)
      send_item(make_req(ACT_FREE_ONE, 32'd1000 + 2 * i, '0, '0), calm);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) == 0) calm = !calm;
      send_item(random_req(), calm);
    end
    req_ch.valid <= 1'b0;

    while (pool.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pool.errors == 0 && pool.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
